[sv/awa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package awa_pkg;

    // Fixed widths of the configuration port, the configuration registers and the result fields.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;
    localparam int OUT_BITS       = 24;
    localparam int ROW_BITS       = 16;
    localparam int PWIDTH_BITS    = 11;
    localparam int HALF_REG_BITS  = 3;

    // Register indexes of the configuration port.
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    localparam cfg_index_t CFG_PADDED_WIDTH  = 3'd0;
    localparam cfg_index_t CFG_PADDED_HEIGHT = 3'd1;
    localparam cfg_index_t CFG_WINDOW_HALF   = 3'd2;
    localparam cfg_index_t CFG_DOUGHNUT_HALF = 3'd3;
    localparam cfg_index_t CFG_ALLOW_GORE    = 3'd4;

    // Largest result value; larger means saturate here.
    localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

endpackage

`default_nettype wire

[sv/annulus_window_average.sv]
`timescale 1ns / 1ps
`default_nettype none
// Every accepted pixel finds its line slot and is stored; with a full window, its window is
// then read at one line store read per cycle, the read data settles, the bit-serial divide
// runs and the output register is loaded. A zero result skips the divide.
// Throughput: one item at a time, and a result not yet taken holds the next one in the last
// stage. Reset clears the counters, the control state and the registers to their defaults;
// the line store contents are not cleared.

module annulus_window_average #(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_HALF    = 7,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [awa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [awa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [SAMPLE_BITS-1:0]              s_band0_sample,
    input  wire logic [SAMPLE_BITS-1:0]              s_band1_sample,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [awa_pkg::OUT_BITS-1:0]        m_band0_average,
    output logic      [awa_pkg::OUT_BITS-1:0]        m_band1_average,
    output logic                                     m_end_of_row,
    output logic                                     m_end_of_frame
);

    import awa_pkg::*;

    localparam int LINES     = 2 * MAX_HALF + 1;
    localparam int LB        = $clog2(LINES);
    localparam int CB        = $clog2(MAX_WIDTH);
    localparam int WB        = $clog2(MAX_WIDTH + 1);
    localparam int HB        = $clog2(MAX_HALF + 1);
    localparam int SPB       = $clog2(2 * MAX_HALF + 1);
    localparam int CNT_BITS  = $clog2(LINES * LINES + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
    localparam int NUM_BITS  = SUM_BITS + FRAC_BITS;
    localparam int AB        = LB + CB;
    localparam int RECIP     = (1 << ROW_BITS) / LINES;
    localparam int RCB       = $clog2(RECIP + 1);
    localparam int PB        = ROW_BITS + RCB;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_MOD, ST_WR, ST_SCAN, ST_DRAIN, ST_DIVS, ST_DIVW, ST_HOLD
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [PWIDTH_BITS-1:0]   padded_width_reg;
    logic [ROW_BITS-1:0]      padded_height_reg;
    logic [HALF_REG_BITS-1:0] window_half_reg, doughnut_half_reg;
    logic                     allow_gore_reg;

    // Effective settings.
    logic [WB-1:0]       w_eff;
    logic [ROW_BITS-1:0] h_eff;
    logic [HB-1:0]       wh_eff, dh_eff;
    logic [SPB-1:0]      span_eff;
    logic [CB-1:0]       c_eff;
    logic [ROW_BITS-1:0] r_eff;

    // Scan position counters.
    logic [CB-1:0]       col_count_reg;
    logic [ROW_BITS-1:0] row_count_reg;

    // Per item context.
    logic [CB-1:0]            c_reg;
    logic [ROW_BITS-1:0]      r_reg;
    logic [2*SAMPLE_BITS-1:0] pix_reg;
    logic [SPB-1:0]           span_reg;
    logic [HB-1:0]            wh_reg, dh_reg;
    logic                     gore_reg, win_reg, eor_reg, eof_reg;
    logic [PB-1:0]            prod_reg;
    logic [LB-1:0]            rslot_reg, slot_reg;
    logic [SPB-1:0]           dy_reg, dx_reg;

    // Read tags, registered so that they line up with the read data.
    logic tag_valid_reg, tag_ring_reg, tag_center_reg;

    // Accumulators.
    logic [SUM_BITS-1:0] sum0_reg, sum1_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                any_zero_reg, center_nz_reg;

    // Result registers.
    logic [OUT_BITS-1:0] res0_reg, res1_reg;
    logic [OUT_BITS-1:0] out0_reg, out1_reg;
    logic                out_eor_reg, out_eof_reg, m_valid_reg;

    logic                     mem_we, mem_re;
    logic [AB-1:0]            mem_waddr, mem_raddr;
    logic [2*SAMPLE_BITS-1:0] mem_rdata;
    logic [SAMPLE_BITS-1:0]   p0, p1;

    logic [ROW_BITS-1:0] quo_row, rem_a, rem_b;
    logic [LB:0]         start_slot;
    logic [CB-1:0]       col_base;
    logic [HB:0]         ady, adx;
    logic                ring_now;

    logic                div_start, div_done;
    logic [NUM_BITS-1:0] quo0, quo1;

    // Clamp the registers to the ranges the datapath supports.
    always_comb begin
        if (padded_width_reg == '0) begin
            w_eff = WB'(1);
        end else if (32'(padded_width_reg) > MAX_WIDTH) begin
            w_eff = WB'(MAX_WIDTH);
        end else begin
            w_eff = WB'(padded_width_reg);
        end
        h_eff = (padded_height_reg == '0) ? ROW_BITS'(1) : padded_height_reg;
        if (window_half_reg == '0) begin
            wh_eff = HB'(1);
        end else if (32'(window_half_reg) > MAX_HALF) begin
            wh_eff = HB'(MAX_HALF);
        end else begin
            wh_eff = HB'(window_half_reg);
        end
        if (32'(doughnut_half_reg) >= 32'(wh_eff)) begin
            dh_eff = wh_eff - 1'b1;
        end else begin
            dh_eff = HB'(doughnut_half_reg);
        end
        span_eff = SPB'({wh_eff, 1'b0});
        c_eff = (32'(col_count_reg) >= 32'(w_eff)) ? CB'(w_eff - 1'b1) : col_count_reg;
        r_eff = (row_count_reg >= h_eff) ? h_eff - 1'b1 : row_count_reg;
    end

    // Row slot as remainder by the line count: reciprocal, then one correction.
    always_comb begin
        quo_row = ROW_BITS'(prod_reg >> ROW_BITS);
        rem_a   = ROW_BITS'(r_reg - ROW_BITS'(quo_row * LINES));
        rem_b   = (32'(rem_a) >= LINES) ? ROW_BITS'(rem_a - ROW_BITS'(LINES)) : rem_a;
    end

    // Window addressing.
    always_comb begin
        start_slot = (LB + 1)'(rslot_reg) + (LB + 1)'(LINES) - (LB + 1)'(span_reg);
        if (32'(start_slot) >= LINES) begin
            start_slot = start_slot - (LB + 1)'(LINES);
        end
        col_base  = c_reg - CB'(span_reg);
        ady = ({1'b0, dy_reg} > (HB + 1)'(wh_reg)) ? (HB + 1)'(dy_reg - SPB'(wh_reg))
                                                   : (HB + 1)'(SPB'(wh_reg) - dy_reg);
        adx = ({1'b0, dx_reg} > (HB + 1)'(wh_reg)) ? (HB + 1)'(dx_reg - SPB'(wh_reg))
                                                   : (HB + 1)'(SPB'(wh_reg) - dx_reg);
        ring_now  = (ady > {1'b0, dh_reg}) || (adx > {1'b0, dh_reg});
        mem_we    = (state_reg == ST_WR);
        mem_waddr = {rslot_reg, c_reg};
        mem_re    = (state_reg == ST_SCAN);
        mem_raddr = {slot_reg, CB'(col_base + CB'(dx_reg))};
    end

    assign p0 = mem_rdata[SAMPLE_BITS-1:0];
    assign p1 = mem_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            padded_width_reg  <= PWIDTH_BITS'(1024);
            padded_height_reg <= ROW_BITS'(3);
            window_half_reg   <= HALF_REG_BITS'(1);
            doughnut_half_reg <= '0;
            allow_gore_reg    <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PADDED_WIDTH:  padded_width_reg  <= cfg_data[PWIDTH_BITS-1:0];
                CFG_PADDED_HEIGHT: padded_height_reg <= cfg_data[ROW_BITS-1:0];
                CFG_WINDOW_HALF:   window_half_reg   <= cfg_data[HALF_REG_BITS-1:0];
                CFG_DOUGHNUT_HALF: doughnut_half_reg <= cfg_data[HALF_REG_BITS-1:0];
                CFG_ALLOW_GORE:    allow_gore_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Accumulate the window as read data returns.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WR) begin
            sum0_reg      <= '0;
            sum1_reg      <= '0;
            cnt_reg       <= '0;
            any_zero_reg  <= 1'b0;
            center_nz_reg <= 1'b0;
        end else if (tag_valid_reg) begin
            if (p0 == '0) begin
                any_zero_reg <= 1'b1;
            end
            if (tag_center_reg) begin
                center_nz_reg <= (p0 != '0);
            end
            if (tag_ring_reg && p0 != '0) begin
                cnt_reg  <= cnt_reg + 1'b1;
                sum0_reg <= sum0_reg + SUM_BITS'(p0);
                sum1_reg <= sum1_reg + SUM_BITS'(p1);
            end
        end
    end

    // Main sequencer with the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            col_count_reg <= '0;
            row_count_reg <= '0;
            tag_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            tag_valid_reg <= 1'b0;
            // The output stage loads its own next item while in the hold state.
            if (m_valid_reg && m_ready && state_reg != ST_HOLD) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        c_reg    <= c_eff;
                        r_reg    <= r_eff;
                        if (s_band0_sample == '0 || s_band1_sample == '0) begin
                            pix_reg <= '0;
                        end else begin
                            pix_reg <= {s_band1_sample, s_band0_sample};
                        end
                        span_reg <= span_eff;
                        wh_reg   <= wh_eff;
                        dh_reg   <= dh_eff;
                        gore_reg <= allow_gore_reg;
                        win_reg  <= (32'(r_eff) >= 32'(span_eff)) &&
                                    (32'(c_eff) >= 32'(span_eff));
                        eor_reg  <= (32'(c_eff) == 32'(w_eff) - 1);
                        eof_reg  <= (32'(c_eff) == 32'(w_eff) - 1) &&
                                    (r_eff == h_eff - 1'b1);
                        if (32'(c_eff) + 1 >= 32'(w_eff)) begin
                            col_count_reg <= '0;
                            row_count_reg <= (32'(r_eff) + 1 >= 32'(h_eff)) ? '0
                                                                             : r_eff + 1'b1;
                        end else begin
                            col_count_reg <= c_eff + 1'b1;
                            row_count_reg <= r_eff;
                        end
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= PB'(r_reg) * PB'(RECIP);
                    state_reg <= ST_MOD;
                end
                ST_MOD: begin
                    rslot_reg <= LB'(rem_b);
                    state_reg <= ST_WR;
                end
                ST_WR: begin
                    dy_reg   <= '0;
                    dx_reg   <= '0;
                    slot_reg <= LB'(start_slot);
                    state_reg <= win_reg ? ST_SCAN : ST_IDLE;
                end
                ST_SCAN: begin
                    tag_valid_reg  <= 1'b1;
                    tag_ring_reg   <= ring_now;
                    tag_center_reg <= (dy_reg == SPB'(wh_reg)) && (dx_reg == SPB'(wh_reg));
                    if (dx_reg == span_reg) begin
                        dx_reg <= '0;
                        if (dy_reg == span_reg) begin
                            state_reg <= ST_DRAIN;
                        end else begin
                            dy_reg   <= dy_reg + 1'b1;
                            slot_reg <= (32'(slot_reg) == LINES - 1) ? '0 : slot_reg + 1'b1;
                        end
                    end else begin
                        dx_reg <= dx_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_DIVS;
                end
                ST_DIVS: begin
                    if (center_nz_reg && !(!gore_reg && any_zero_reg) && cnt_reg != '0) begin
                        state_reg <= ST_DIVW;
                    end else begin
                        res0_reg  <= '0;
                        res1_reg  <= '0;
                        state_reg <= ST_HOLD;
                    end
                end
                ST_DIVW: begin
                    if (div_done) begin
                        res0_reg  <= (64'(quo0) > 64'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(quo0);
                        res1_reg  <= (64'(quo1) > 64'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(quo1);
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (!m_valid_reg || m_ready) begin
                        out0_reg    <= res0_reg;
                        out1_reg    <= res1_reg;
                        out_eor_reg <= eor_reg;
                        out_eof_reg <= eof_reg;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign div_start = (state_reg == ST_DIVS) && center_nz_reg &&
                       !(!gore_reg && any_zero_reg) && (cnt_reg != '0);

    awa_line_store #(
        .ADDR_BITS (AB),
        .DATA_BITS (2 * SAMPLE_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (pix_reg),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    awa_divider #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (CNT_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num0    ({sum0_reg, FRAC_BITS'(0)}),
        .num1    ({sum1_reg, FRAC_BITS'(0)}),
        .den     (cnt_reg),
        .done    (div_done),
        .quo0    (quo0),
        .quo1    (quo1)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_band0_average = out0_reg;
    assign m_band1_average = out1_reg;
    assign m_end_of_row    = out_eor_reg;
    assign m_end_of_frame  = out_eof_reg;

endmodule

`default_nettype wire

[sv/awa_line_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module awa_line_store #(
    parameter int ADDR_BITS = 14,
    parameter int DATA_BITS = 32
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [DATA_BITS-1:0] wr_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[sv/awa_divider.sv]
`timescale 1ns / 1ps
`default_nettype none

module awa_divider #(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                start,
    input  wire logic [NUM_BITS-1:0] num0,
    input  wire logic [NUM_BITS-1:0] num1,
    input  wire logic [DEN_BITS-1:0] den,
    output logic                     done,
    output logic      [NUM_BITS-1:0] quo0,
    output logic      [NUM_BITS-1:0] quo1
);

    localparam int STEP_BITS = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0]  n0_reg, n0_next, n1_reg, n1_next;
    logic [DEN_BITS-1:0]  r0_reg, r0_next, r1_reg, r1_next;
    logic [DEN_BITS-1:0]  den_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic                 run_reg, done_reg;
    logic [DEN_BITS:0]    sh0, sh1;

    // One restoring quotient bit per cycle for each band.
    always_comb begin
        sh0 = {r0_reg, n0_reg[NUM_BITS-1]};
        sh1 = {r1_reg, n1_reg[NUM_BITS-1]};
        if (sh0 >= {1'b0, den_reg}) begin
            r0_next = DEN_BITS'(sh0 - {1'b0, den_reg});
            n0_next = {n0_reg[NUM_BITS-2:0], 1'b1};
        end else begin
            r0_next = sh0[DEN_BITS-1:0];
            n0_next = {n0_reg[NUM_BITS-2:0], 1'b0};
        end
        if (sh1 >= {1'b0, den_reg}) begin
            r1_next = DEN_BITS'(sh1 - {1'b0, den_reg});
            n1_next = {n1_reg[NUM_BITS-2:0], 1'b1};
        end else begin
            r1_next = sh1[DEN_BITS-1:0];
            n1_next = {n1_reg[NUM_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg  <= 1'b1;
                step_reg <= '0;
                n0_reg   <= num0;
                n1_reg   <= num1;
                r0_reg   <= '0;
                r1_reg   <= '0;
                den_reg  <= den;
            end else if (run_reg) begin
                n0_reg   <= n0_next;
                n1_reg   <= n1_next;
                r0_reg   <= r0_next;
                r1_reg   <= r1_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_BITS'(NUM_BITS - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo0 = n0_reg;
    assign quo1 = n1_reg;

endmodule

`default_nettype wire

[verif/annulus_window_average_checker.sv]
`timescale 1ns / 1ps

module annulus_window_average_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [awa_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [awa_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic [15:0]                         s_band0_sample,
    input  wire logic [15:0]                         s_band1_sample,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [awa_pkg::OUT_BITS-1:0]        m_band0_average,
    input  wire logic [awa_pkg::OUT_BITS-1:0]        m_band1_average,
    input  wire logic                                m_end_of_row,
    input  wire logic                                m_end_of_frame,
    output int                                       fail_count,
    output int                                       pending,
    output int                                       results_seen
);
    import awa_pkg::*;

    localparam int LINES = 15;
    localparam int MAXW  = 1024;
    localparam int MAXH  = 7;

    typedef struct packed {
        logic [OUT_BITS-1:0] avg0;
        logic [OUT_BITS-1:0] avg1;
        logic                eor;
        logic                eof;
    } ring_mean_t;

    ring_mean_t means_due[$];

    // Own copy of the pixel history and of the registers.
    logic [15:0] hist0 [LINES][MAXW];
    logic [15:0] hist1 [LINES][MAXW];
    int unsigned col_pos, row_pos;
    logic [10:0] reg_width;
    logic [15:0] reg_height;
    logic [2:0]  reg_whalf, reg_dhalf;
    logic        reg_gore;

    assign pending = means_due.size();

    function automatic logic [OUT_BITS-1:0] ring_mean(longint unsigned sum, int unsigned cnt);
        longint unsigned q;
        q = (sum << 8) / cnt;
        return (q > longint'(OUT_MAX)) ? OUT_MAX : q[OUT_BITS-1:0];
    endfunction

    // Store the pixel and, where a full window is present, queue its ring mean.
    task automatic take_pixel(input logic [15:0] b0, input logic [15:0] b1);
        int unsigned w, h, wh, dh, c, r, rslot, span, slot, ady, adx, col, cnt;
        longint unsigned sum0, sum1;
        logic any_zero;
        ring_mean_t m;
        w  = (reg_width == 0) ? 1 : ((reg_width > MAXW) ? MAXW : reg_width);
        h  = (reg_height == 0) ? 1 : reg_height;
        wh = (reg_whalf == 0) ? 1 : ((reg_whalf > MAXH) ? MAXH : reg_whalf);
        dh = (reg_dhalf >= wh) ? wh - 1 : reg_dhalf;
        c  = (col_pos >= w) ? w - 1 : col_pos;
        r  = (row_pos >= h) ? h - 1 : row_pos;
        rslot = r % LINES;
        // A pixel missing either band is no data in both.
        if (b0 == 0 || b1 == 0) begin
            b0 = 0;
            b1 = 0;
        end
        hist0[rslot][c] = b0;
        hist1[rslot][c] = b1;
        if (r >= 2 * wh && c >= 2 * wh) begin
            span = 2 * wh;
            sum0 = 0;
            sum1 = 0;
            cnt = 0;
            any_zero = 1'b0;
            for (int dy = 0; dy <= span; dy++) begin
                slot = (rslot + LINES - (span - dy)) % LINES;
                ady = (dy > wh) ? dy - wh : wh - dy;
                for (int dx = 0; dx <= span; dx++) begin
                    col = c - span + dx;
                    adx = (dx > wh) ? dx - wh : wh - dx;
                    if (hist0[slot][col] == 0) any_zero = 1'b1;
                    if ((ady > dh || adx > dh) && hist0[slot][col] != 0) begin
                        cnt++;
                        sum0 += hist0[slot][col];
                        sum1 += hist1[slot][col];
                    end
                end
            end
            m = '0;
            if (hist0[(rslot + LINES - wh) % LINES][c - wh] != 0 &&
                !(reg_gore == 1'b0 && any_zero) && cnt > 0) begin
                m.avg0 = ring_mean(sum0, cnt);
                m.avg1 = ring_mean(sum1, cnt);
            end
            m.eor = (c == w - 1);
            m.eof = (c == w - 1) && (r == h - 1);
            means_due.push_back(m);
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        results_seen = 0;
        foreach (hist0[i, j]) begin
            hist0[i][j] = '0;
            hist1[i][j] = '0;
        end
    end

    // Results are checked before the same edge's input is predicted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            col_pos    <= 0;
            row_pos    <= 0;
            reg_width  <= 11'd1024;
            reg_height <= 16'd3;
            reg_whalf  <= 3'd1;
            reg_dhalf  <= 3'd0;
            reg_gore   <= 1'b1;
            means_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (means_due.size() == 0) begin
                    report_mismatch("unexpected result, band0_average", m_band0_average, 0);
                end else begin
                    ring_mean_t e;
                    e = means_due.pop_front();
                    if (m_band0_average !== e.avg0)
                        report_mismatch("band0_average", m_band0_average, e.avg0);
                    if (m_band1_average !== e.avg1)
                        report_mismatch("band1_average", m_band1_average, e.avg1);
                    if (m_end_of_row !== e.eor)
                        report_mismatch("end_of_row", m_end_of_row, e.eor);
                    if (m_end_of_frame !== e.eof)
                        report_mismatch("end_of_frame", m_end_of_frame, e.eof);
                end
            end
            if (s_valid && s_ready)
                take_pixel(s_band0_sample, s_band1_sample);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PADDED_WIDTH:  reg_width  <= cfg_data[10:0];
                    CFG_PADDED_HEIGHT: reg_height <= cfg_data[15:0];
                    CFG_WINDOW_HALF:   reg_whalf  <= cfg_data[2:0];
                    CFG_DOUGHNUT_HALF: reg_dhalf  <= cfg_data[2:0];
                    CFG_ALLOW_GORE:    reg_gore   <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

endmodule

[verif/annulus_window_average_tb.sv]
`timescale 1ns / 1ps

module annulus_window_average_tb;
    import awa_pkg::*;

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_PADDED_WIDTH;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [15:0]               s_band0_sample = '0;
    logic [15:0]               s_band1_sample = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [OUT_BITS-1:0]       m_band0_average, m_band1_average;
    logic                      m_end_of_row, m_end_of_frame;
    int                        fail_count, pending, results_seen;
    int                        tx_idle = 0, rx_idle = 0;
    int                        pixels_sent = 0, frames_sent = 0;

    annulus_window_average u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_band0_sample(s_band0_sample), .s_band1_sample(s_band1_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_band0_average(m_band0_average), .m_band1_average(m_band1_average),
        .m_end_of_row(m_end_of_row), .m_end_of_frame(m_end_of_frame)
    );

    annulus_window_average_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_band0_sample(s_band0_sample), .s_band1_sample(s_band1_sample),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_band0_average(m_band0_average), .m_band1_average(m_band1_average),
        .m_end_of_row(m_end_of_row), .m_end_of_frame(m_end_of_frame),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The receiver stalls at the rate of the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle);
    end

    initial begin
        #50ms;
        $display("annulus_window_average: mismatch");
        $finish;
    end

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_BITS-1:0];
        @(posedge aclk);
    endtask

    task automatic set_regs(input int unsigned w, input int unsigned h, input int unsigned wh,
                            input int unsigned dh, input int unsigned gore);
        write_reg(CFG_PADDED_WIDTH, w);
        write_reg(CFG_PADDED_HEIGHT, h);
        write_reg(CFG_WINDOW_HALF, wh);
        write_reg(CFG_DOUGHNUT_HALF, dh);
        write_reg(CFG_ALLOW_GORE, gore);
        cfg_we <= 1'b0;
    endtask

    // Let every expected result drain, then cover the block's longest window pass.
    task automatic drain;
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    task automatic send_pixel(input logic [15:0] b0, input logic [15:0] b1);
        if ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle);
        end
        s_valid        <= 1'b1;
        s_band0_sample <= b0;
        s_band1_sample <= b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pixels_sent++;
    endtask

    function automatic logic [15:0] rand_sample(input int zero_pct);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < zero_pct) return 16'd0;
        if (pick < zero_pct + 4) return 16'hFFFF;
        if (pick < zero_pct + 8) return 16'd1;
        return 16'($urandom_range(65535, 1));
    endfunction

    task automatic send_frame(input int unsigned w, input int unsigned h, input int zero_pct);
        for (int unsigned i = 0; i < w * h; i++)
            send_pixel(rand_sample(zero_pct), rand_sample(zero_pct));
        frames_sent++;
    endtask

    // Directed 3x3 frame: ring of extremes with one band-only gap, center at full scale.
    task automatic send_extreme_frame;
        for (int i = 0; i < 9; i++) begin
            if (i == 4) send_pixel(16'hFFFF, 16'hFFFF);
            else if (i == 7) send_pixel(16'h1234, 16'h0000);
            else if (i % 2 == 0) send_pixel(16'hFFFF, 16'h0001);
            else send_pixel(16'h0001, 16'hFFFF);
        end
        frames_sent++;
    endtask

    initial begin
        int unsigned wh, eff, dh, w, h, ew, eh;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames: extremes, whole-window rejection with clamped halves, empty ring,
        // zero center, and the degenerate one-pixel frame.
        set_regs(3, 3, 1, 0, 1);
        send_extreme_frame();
        drain();
        set_regs(3, 3, 0, 7, 0);
        send_extreme_frame();
        drain();
        set_regs(3, 3, 1, 0, 1);
        for (int i = 0; i < 9; i++)
            send_pixel(i == 4 ? 16'd7 : 16'd0, 16'd9);
        frames_sent++;
        drain();
        set_regs(3, 3, 1, 0, 1);
        for (int i = 0; i < 9; i++)
            send_pixel(i == 4 ? 16'd0 : 16'd500, 16'd600);
        frames_sent++;
        drain();
        set_regs(0, 0, 7, 6, 1);
        send_pixel(16'd3, 16'd4);
        frames_sent++;
        drain();
        set_regs(15, 65535, 7, 6, 0);

        // Random frames across three stall phases.
        while (pixels_sent < 1200) begin
            if (pixels_sent < 420) begin
                tx_idle = 6;
                rx_idle = 70;
            end else if (pixels_sent < 820) begin
                tx_idle = 70;
                rx_idle = 6;
            end else begin
                tx_idle = 0;
                rx_idle = 0;
            end
            case ($urandom_range(9))
                0: wh = 0;
                1: wh = $urandom_range(7, 4);
                default: wh = $urandom_range(3, 1);
            endcase
            eff = (wh == 0) ? 1 : wh;
            dh = $urandom_range(7);
            if ($urandom_range(9) == 0) begin
                w = $urandom_range(2 * eff);
                h = $urandom_range(2 * eff);
            end else begin
                w = $urandom_range(2 * eff + ((eff > 3) ? 3 : 8), 2 * eff + 1);
                h = $urandom_range(2 * eff + ((eff > 3) ? 2 : 6), 2 * eff + 1);
            end
            ew = (w == 0) ? 1 : w;
            eh = (h == 0) ? 1 : h;
            drain();
            set_regs(w, h, wh, dh, $urandom_range(1));
            send_frame(ew, eh, ($urandom_range(3) == 0) ? 0 : $urandom_range(30));
        end
        drain();

        $display("Sent %0d pixels in %0d frames; %0d ring means checked.",
                 pixels_sent, frames_sent, results_seen);
        $display("Covered clamped registers, gore on and off, and three stall phases.");
        if (fail_count == 0) begin
            $display("annulus_window_average: match");
        end else begin
            $display("annulus_window_average: mismatch");
        end
        $finish;
    end

endmodule
